// File: hdl/assert_macros.svh
// Assertion helper macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication on the same edge, clocked on clk_i, quiet during reset.
`define SIRT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication on the following edge, clocked on clk_i, quiet during reset.
`define SIRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sirt_pkg.sv
// ---------------------------------------------------------------------------
// sirt_pkg
// Shared types, constants and the digit-to-character function for the
// signed integer to radix text converter.
// ---------------------------------------------------------------------------
package sirt_pkg;

  localparam int unsigned BITS_PER_STEP = 8;   // dividend bits retired per divide cycle
  localparam int unsigned DIGIT_W       = 6;
  localparam int unsigned CHAR_W        = 8;

  localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 6'd35;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA  = 8'h57;  // 'a' - 10
  localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_FETCH,
    ST_SHOW
  } sirt_state_e;

  typedef struct packed {
    logic load;    // capture magnitude and sign, clear digit count
    logic step;    // run the divider on the top dividend byte
    logic sign;    // put out '-'
    logic show;    // put out the fetched digit
    logic empty;   // put out the empty word
  } sirt_cmd_t;

  typedef struct packed {
    logic radix_ok;
    logic neg;
    logic step_last;   // this divide cycle finishes a digit
    logic quot_zero;   // quotient after this cycle is zero
    logic digit_last;  // the digit being shown is the final one
  } sirt_sts_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] c;
    begin
      c = (d > DIGIT_MAX) ? DIGIT_MAX : d;
      if (c < DIGIT_TEN) begin
        glyph = CHAR_ZERO + CHAR_W'(c);
      end else begin
        glyph = CHAR_ALPHA + CHAR_W'(c);
      end
    end
  endfunction

endpackage

// File: hdl/sirt_ram.sv
// ---------------------------------------------------------------------------
// sirt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sirt_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/sirt_ctrl.sv
// ---------------------------------------------------------------------------
// sirt_ctrl
// Sequencer: empty word for an invalid radix, else divide phase, optional sign,
// then fetch/show per digit.
module sirt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  sirt_pkg::sirt_sts_t sts_i,
  output sirt_pkg::sirt_cmd_t cmd_o,
  output logic                busy_o
);
  import sirt_pkg::*;

  sirt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (sts_i.radix_ok) begin
            cmd_o.load = 1'b1;
            state_d    = ST_DIV;
          end else begin
            cmd_o.empty = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.step_last && sts_i.quot_zero) begin
          state_d = sts_i.neg ? ST_SIGN : ST_FETCH;
        end
      end
      ST_SIGN: begin
        cmd_o.sign = 1'b1;
        state_d    = ST_FETCH;
      end
      ST_FETCH: begin
        // store read address is already on the RAM; data registers this cycle
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        cmd_o.show = 1'b1;
        state_d    = ST_FETCH;
        if (sts_i.digit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// File: hdl/sirt_dp.sv
// ---------------------------------------------------------------------------
// sirt_dp
// Datapath: radix register, digit-serial divider (8 bits per cycle), digit
// store and registered output word.
// ---------------------------------------------------------------------------
module sirt_dp #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          radix_we_i,
  input  logic [sirt_pkg::DIGIT_W-1:0]  radix_i,
  input  logic signed [VALUE_WIDTH-1:0] number_i,
  input  sirt_pkg::sirt_cmd_t           cmd_i,
  output sirt_pkg::sirt_sts_t           sts_o,
  output logic                          strobe_o,
  output logic [sirt_pkg::CHAR_W-1:0]   char_code_o,
  output logic                          last_o,
  output logic                          empty_res_o
);
  import sirt_pkg::*;

  localparam int unsigned STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned PW    = STEPS * BITS_PER_STEP;
  localparam int unsigned SW    = $clog2(STEPS + 1);
  localparam int unsigned DEPTH = VALUE_WIDTH + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(VALUE_WIDTH + 2);

  logic [DIGIT_W-1:0] radix_q;
  logic [SW-1:0]      step_q;
  logic [CW-1:0]      cnt_q;
  logic               neg_q;
  logic [PW-1:0]      quo_q;
  logic [DIGIT_W-1:0] rem_q;

  logic                     strobe_q;
  logic [CHAR_W-1:0]        char_q;
  logic                     last_q;
  logic                     empty_q;

  logic [PW-1:0]            quo_n;
  logic [DIGIT_W-1:0]       rem_n;
  logic [BITS_PER_STEP-1:0] qbit_v;
  logic [VALUE_WIDTH-1:0]   num_u;
  logic [VALUE_WIDTH-1:0]   mag;
  logic                     step_last;
  logic                     store_we;
  logic [AW-1:0]            raddr;
  logic [DIGIT_W-1:0]       rdata;
  logic                     cnt_one;

  assign num_u = $unsigned(number_i);
  assign mag   = num_u[VALUE_WIDTH-1] ? (~num_u + 1'b1) : num_u;

  // restoring division of the top dividend byte by the radix, MSB first
  always_comb begin
    logic [DIGIT_W-1:0]       rem_v;
    logic [DIGIT_W:0]         trial_v;
    logic [BITS_PER_STEP-1:0] top_v;
    rem_v   = rem_q;
    top_v   = quo_q[PW-1 -: BITS_PER_STEP];
    qbit_v  = '0;
    trial_v = '0;
    for (int i = BITS_PER_STEP - 1; i >= 0; i--) begin
      trial_v = {rem_v, top_v[i]};
      if (trial_v >= {1'b0, radix_q}) begin
        trial_v   = trial_v - {1'b0, radix_q};
        qbit_v[i] = 1'b1;
      end
      rem_v = trial_v[DIGIT_W-1:0];
    end
    rem_n = rem_v;
  end

  assign quo_n     = (quo_q << BITS_PER_STEP) | PW'(qbit_v);
  assign step_last = (step_q == SW'(STEPS - 1));
  assign store_we  = cmd_i.step && step_last;
  assign raddr     = AW'(cnt_q - 1'b1);
  assign cnt_one   = (cnt_q == CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= RADIX_RESET;
      step_q   <= '0;
      cnt_q    <= '0;
      neg_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      if (radix_we_i) begin
        radix_q <= radix_i;
      end
      if (cmd_i.load) begin
        step_q <= '0;
        cnt_q  <= '0;
        neg_q  <= num_u[VALUE_WIDTH-1];
      end else if (cmd_i.step) begin
        step_q <= step_last ? '0 : step_q + 1'b1;
        if (step_last) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else if (cmd_i.show) begin
        cnt_q <= cnt_q - 1'b1;
      end
      strobe_q <= cmd_i.empty || cmd_i.sign || cmd_i.show;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quo_q <= PW'(mag);
      rem_q <= '0;
    end else if (cmd_i.step) begin
      quo_q <= quo_n;
      rem_q <= step_last ? '0 : rem_n;
    end
    priority if (cmd_i.empty) begin
      char_q  <= CHAR_NONE;
      last_q  <= 1'b1;
      empty_q <= 1'b1;
    end else if (cmd_i.sign) begin
      char_q  <= CHAR_MINUS;
      last_q  <= 1'b0;
      empty_q <= 1'b0;
    end else if (cmd_i.show) begin
      char_q  <= glyph(rdata);
      last_q  <= cnt_one;
      empty_q <= 1'b0;
    end
  end

  sirt_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (rem_n),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    sts_o.radix_ok   = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);
    sts_o.neg        = neg_q;
    sts_o.step_last  = step_last;
    sts_o.quot_zero  = (quo_n == '0);
    sts_o.digit_last = cnt_one;
  end

  assign strobe_o    = strobe_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;
  assign empty_res_o = empty_q;

endmodule

// File: hdl/signed_integer_to_radix_text.sv
// ---------------------------------------------------------------------------
// signed_integer_to_radix_text
// Converts a signed integer to lower-case text in base 2..36, one character
// per output word, most significant first, '-' ahead of negative values.
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------
//  input    | start, busy             | number_i
//  output   | strobe_o (one cycle)    | char_code_o, last_o, empty_res_o
//  config   | radix_we_i              | radix_i
//
//  All digits come from one shared radix divider (8 quotient bits per cycle)
//  and go to a digit store; after the '-' word for a negative value, each
//  digit is read back from the store, most significant first, and put out.
//  An invalid radix gives the empty word the cycle after start, busy stays low.
//  Reset is asynchronous, active low; radix resets to 10.
//  Output words are not held: the receiver takes each one in its cycle.
// ---------------------------------------------------------------------------
module signed_integer_to_radix_text #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] number_i,
  input  logic                          radix_we_i,
  input  logic [sirt_pkg::DIGIT_W-1:0]  radix_i,
  output logic                          strobe_o,
  output logic [sirt_pkg::CHAR_W-1:0]   char_code_o,
  output logic                          last_o,
  output logic                          empty_res_o
);
  import sirt_pkg::*;

  sirt_cmd_t cmd;
  sirt_sts_t sts;

  sirt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  sirt_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radix_we_i  (radix_we_i),
    .radix_i     (radix_i),
    .number_i    (number_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .strobe_o    (strobe_o),
    .char_code_o (char_code_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o)
  );

endmodule

// File: hdl/sirt_checker.sv
// ---------------------------------------------------------------------------
// sirt_checker
// Port-level checks for the radix text converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sirt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          strobe_o,
  input logic [sirt_pkg::CHAR_W-1:0]   char_code_o,
  input logic                          last_o,
  input logic                          empty_res_o
);
  import sirt_pkg::*;

  // empty word is a single, final word with no character
  `SIRT_ASSERT_SAME(a_empty_last, strobe_o && empty_res_o, last_o && (char_code_o == CHAR_NONE), "empty word not final or not blank")
  // a real character is never blank
  `SIRT_ASSERT_SAME(a_char_set, strobe_o && !empty_res_o, char_code_o != CHAR_NONE, "blank character word")
  // more characters follow, so the block must still be working
  `SIRT_ASSERT_SAME(a_more_busy, strobe_o && !last_o, busy, "idle before last word")
  // no word appears out of an idle cycle without start
  `SIRT_ASSERT_NEXT(a_no_spurious, !busy && !start, !strobe_o, "word without work")

endmodule

bind signed_integer_to_radix_text sirt_checker u_sirt_checker (.*);

// File: bench/signed_integer_to_radix_text_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// signed_integer_to_radix_text_test
// Self-checking bench for the radix text converter. It sends signed numbers
// under a range of radix settings, spells each accepted number in software
// and compares every output word, field by field, in order.
// ---------------------------------------------------------------------------
module signed_integer_to_radix_text_test;
  import sirt_pkg::*;

  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam int unsigned       MAX_PRINTS   = 40;
  localparam int unsigned       RANDOM_ITEMS = 180;
  localparam int unsigned       QUIET_TAIL   = 40;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              empty;
  } char_word_t;

  class text_checker;
    logic [DIGIT_W-1:0] base;
    char_word_t         pending_chars[$];
    int unsigned        mismatches;
    int unsigned        numbers_seen;
    int unsigned        chars_seen;
    int unsigned        empty_seen;

    function new();
      base = RADIX_RESET;
    endfunction

    function logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      if (d < DIGIT_TEN) begin
        return CHAR_ZERO + CHAR_W'(d);
      end
      return CHAR_LOWER_A + CHAR_W'(d - DIGIT_TEN);
    endfunction

    // Spell one accepted number in the current base and queue its words.
    function void note_number(input logic signed [31:0] value);
      logic [31:0]        mag;
      logic [DIGIT_W-1:0] digits [33];
      int                 count;
      char_word_t         w;
      numbers_seen++;
      if (base < RADIX_MIN || base > RADIX_MAX) begin
        w = '{code: CHAR_NONE, last: 1'b1, empty: 1'b1};
        pending_chars.push_back(w);
        return;
      end
      mag = value;
      if (value[31]) begin
        mag = ~mag + 32'd1;  // most negative value stays 2^31 as unsigned
      end
      count = 0;
      do begin
        digits[count] = DIGIT_W'(mag % 32'(base));
        mag = mag / 32'(base);
        count++;
      end while (mag != 32'd0);
      if (value[31]) begin
        w = '{code: CHAR_MINUS, last: 1'b0, empty: 1'b0};
        pending_chars.push_back(w);
      end
      for (int i = count - 1; i >= 0; i--) begin
        w = '{code: digit_char(digits[i]), last: (i == 0), empty: 1'b0};
        pending_chars.push_back(w);
      end
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
    endtask

    task check_char(input logic [CHAR_W-1:0] code, input logic last, input logic empty);
      char_word_t w;
      chars_seen++;
      if (empty) begin
        empty_seen++;
      end
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with none expected (code %02h)",
                                  chars_seen, code));
        return;
      end
      w = pending_chars.pop_front();
      if (code !== w.code) begin
        report_mismatch($sformatf("word %0d char_code %02h, expected %02h",
                                  chars_seen, code, w.code));
      end
      if (last !== w.last) begin
        report_mismatch($sformatf("word %0d last %b, expected %b", chars_seen, last, w.last));
      end
      if (empty !== w.empty) begin
        report_mismatch($sformatf("word %0d empty_res %b, expected %b",
                                  chars_seen, empty, w.empty));
      end
    endtask
  endclass

  logic                      clk_i      = 1'b0;
  logic                      rst_ni     = 1'b0;
  logic                      start      = 1'b0;
  logic                      busy;
  logic signed [31:0]        number_i   = '0;
  logic                      radix_we_i = 1'b0;
  logic [DIGIT_W-1:0]        radix_i    = '0;
  logic                      strobe_o;
  logic [CHAR_W-1:0]         char_code_o;
  logic                      last_o;
  logic                      empty_res_o;

  text_checker board;
  bit          idle_on;
  int unsigned idle_pct;
  logic [63:0] bases_used = '0;

  signed_integer_to_radix_text #(
    .VALUE_WIDTH(32)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .number_i   (number_i),
    .radix_we_i (radix_we_i),
    .radix_i    (radix_i),
    .strobe_o   (strobe_o),
    .char_code_o(char_code_o),
    .last_o     (last_o),
    .empty_res_o(empty_res_o)
  );

  always #10 clk_i = ~clk_i;

  // Everything is sampled on the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (radix_we_i) begin
        board.base = radix_i;
      end
      if (start && !busy) begin
        board.note_number(number_i);
        bases_used[board.base] = 1'b1;
      end
      if (strobe_o) begin
        board.check_char(char_code_o, last_o, empty_res_o);
      end
    end
  end

  task automatic send_number(input logic signed [31:0] value);
    start    <= 1'b1;
    number_i <= value;
    do @(posedge clk_i); while (busy);
  endtask

  // Random sender gap after a number was taken.
  task automatic rest();
    int n;
    if (idle_on && $urandom_range(0, 99) < idle_pct) begin
      n = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold off until every expected word is out and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (board.pending_chars.size() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_radix(input logic [DIGIT_W-1:0] v);
    radix_we_i <= 1'b1;
    radix_i    <= v;
    @(posedge clk_i);
    radix_we_i <= 1'b0;
    radix_i    <= DIGIT_W'($urandom);  // must be ignored with the enable low
  endtask

  function automatic logic [DIGIT_W-1:0] pick_radix();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 6'd0;
          1:       return 6'd1;
          2:       return 6'd63;
          default: return DIGIT_W'($urandom_range(37, 63));
        endcase
      end
      1:       return RADIX_MIN;
      2:       return RADIX_MAX;
      default: return DIGIT_W'($urandom_range(2, 36));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_number();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: return $signed($urandom_range(0, 80)) - 32'sd40;
      1: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return 32'sd0;
          3:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      2: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) begin
          v = ~v + 32'd1;
        end
        return $signed(v);
      end
      default: return $signed($urandom);
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase_no;
    int unsigned phase_len;
    board   = new();
    idle_on = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset base first, then binary, base 36, hex and invalid bases.
    send_number(32'sd0);
    send_number(32'sd7);
    send_number(-32'sd1);
    send_number(32'sh7fff_ffff);
    send_number(32'sh8000_0000);
    send_number(32'sd1000000007);
    drain();
    set_radix(RADIX_MIN);
    send_number(32'sh8000_0000);
    send_number(32'sh7fff_ffff);
    send_number(-32'sd1);
    send_number(32'sd1);
    send_number(32'sd0);
    drain();
    set_radix(RADIX_MAX);
    send_number(32'sd35);
    send_number(-32'sd35);
    send_number(32'sd36);
    send_number(32'sh7fff_ffff);
    send_number(32'sh8000_0000);
    drain();
    set_radix(6'd16);
    send_number(32'shdead_beef);
    send_number(32'sd255);
    drain();
    set_radix(6'd0);
    send_number(32'sd5);
    drain();
    set_radix(6'd1);
    send_number(-32'sd5);
    send_number(32'sd0);
    drain();
    set_radix(6'd37);
    send_number(32'sd0);
    drain();
    set_radix(6'd63);
    send_number(32'sh8000_0000);
    send_number(32'sh7fff_ffff);
    drain();

    // Random phases, each under its own radix.
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      set_radix(pick_radix());
      phase_len = $urandom_range(6, 20);
      idle_on   = (sent + QUIET_TAIL < RANDOM_ITEMS);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 30;
        default: idle_pct = 70;
      endcase
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        send_number(pick_number());
        sent++;
        if (phase_no == 0 && k == 3) begin
          drain();
        end else begin
          rest();
        end
      end
      drain();
      phase_no++;
    end

    repeat (20) @(posedge clk_i);
    $display("Covered %0d numbers in %0d random phases, %0d words out, %0d empty words.",
             board.numbers_seen, phase_no, board.chars_seen, board.empty_seen);
    $display("Distinct radix settings exercised: %0d", $countones(bases_used));
    if (board.mismatches == 0 && board.pending_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout waiting for the converter");
    $display("Verification failed");
    $finish;
  end

endmodule
